// ===== rtl/repeating_timer_bank_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Timer bank scheduler assertion macros
// Shared property forms for the checker, clocked on clk_i and held off by
// an active-low rst_ni.
// ----------------------------------------------------------------------------
`ifndef REPEATING_TIMER_BANK_SCHEDULER_DEFINES_SVH
`define REPEATING_TIMER_BANK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTBS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rtbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer bank scheduler package
// Item types, command codes and default sizes shared by the scheduler files.
// ----------------------------------------------------------------------------
`default_nettype none

package rtbs_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int TIME_BITS_DEF   = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int SLOT_FIELD_W = 3;
  localparam int TIME_FIELD_W = 24;
  localparam int COUNT_W      = 8;

  localparam logic [COUNT_W-1:0] REP_FOREVER = 8'hFF;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_SCHED_TIMER,
    ACT_SCHED_FRAME,
    ACT_REMOVE_FRAME
  } action_e;

  typedef enum logic [1:0] {
    KIND_FRAME,
    KIND_ONCE,
    KIND_REP,
    KIND_END
  } kind_e;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ONCE_SET,
    OP_REP_SET,
    OP_FRAME_SET,
    OP_FRAME_CLR
  } op_e;

  typedef struct packed {
    action_e                   action;
    logic [SLOT_FIELD_W-1:0]   slot;
    logic [TIME_FIELD_W-1:0]   interval;
    logic [COUNT_W-1:0]        repeat_count;
    logic                      start_paused;
    logic [TIME_FIELD_W-1:0]   delta_time;
  } item_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0]   fired_slot;
    kind_e                     fired_kind;
    logic [TIME_FIELD_W-1:0]   passed_time;
    logic                      last;
  } res_t;

  typedef struct packed {
    op_e                       op;
    logic [SLOT_FIELD_W-1:0]   slot;
    logic [TIME_FIELD_W-1:0]   interval;
    logic [COUNT_W-1:0]        repeat_count;
    logic                      paused;
    logic [TIME_FIELD_W-1:0]   delta_time;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ===== rtl/rtbs_front.sv =====
// ----------------------------------------------------------------------------
// Timer bank scheduler front end
// Accepts items, drops those aimed at missing slots and turns the rest into
// commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbs_front #(
  parameter int SLOTS = rtbs_pkg::SLOTS_DEF
) (
  input  logic           start_i,
  input  rtbs_pkg::item_t item_i,
  input  rtbs_pkg::qstat_t qstat_i,
  output logic           busy_o,
  output logic           push_o,
  output rtbs_pkg::cmd_t cmd_o
);

  logic in_range;
  logic keep;

  assign busy_o   = qstat_i.full;
  assign in_range = (32'(item_i.slot) < SLOTS);

  always_comb begin
    keep         = in_range;
    cmd_o.op     = rtbs_pkg::OP_TICK;
    case (item_i.action)
      rtbs_pkg::ACT_TICK: begin
        cmd_o.op = rtbs_pkg::OP_TICK;
        keep     = 1'b1;
      end
      rtbs_pkg::ACT_SCHED_TIMER: begin
        // A zero count means a one-shot; anything else is a repeating timer.
        if (item_i.repeat_count == '0) begin
          cmd_o.op = rtbs_pkg::OP_ONCE_SET;
        end else begin
          cmd_o.op = rtbs_pkg::OP_REP_SET;
        end
      end
      rtbs_pkg::ACT_SCHED_FRAME: begin
        cmd_o.op = rtbs_pkg::OP_FRAME_SET;
      end
      rtbs_pkg::ACT_REMOVE_FRAME: begin
        cmd_o.op = rtbs_pkg::OP_FRAME_CLR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    cmd_o.slot         = item_i.slot;
    cmd_o.interval     = item_i.interval;
    cmd_o.repeat_count = item_i.repeat_count;
    cmd_o.paused       = item_i.start_paused;
    cmd_o.delta_time   = item_i.delta_time;
  end

  assign push_o = start_i && !qstat_i.full && keep;

endmodule

`default_nettype wire

// ===== rtl/rtbs_queue.sv =====
// ----------------------------------------------------------------------------
// Timer bank scheduler command queue
// A short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbs_queue #(
  parameter int DEPTH = rtbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rtbs_pkg::cmd_t   cmd_i,
  input  logic             pop_i,
  output rtbs_pkg::cmd_t   cmd_o,
  output rtbs_pkg::qstat_t stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtbs_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rtbs_back.sv =====
// ----------------------------------------------------------------------------
// Timer bank scheduler back end
// Holds the three slot tables, applies schedule commands and walks the
// tables one slot per cycle on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbs_back #(
  parameter int SLOTS     = rtbs_pkg::SLOTS_DEF,
  parameter int TIME_BITS = rtbs_pkg::TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rtbs_pkg::cmd_t   cmd_i,
  input  rtbs_pkg::qstat_t qstat_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output rtbs_pkg::res_t   res_o
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_ONCE,
    ST_REP,
    ST_END
  } state_e;

  state_e                      state_q;
  logic [SLOT_W-1:0]           idx_q;
  logic [TIME_BITS-1:0]        dt_q;
  logic                        res_valid_q;
  rtbs_pkg::res_t              res_q;

  logic [SLOTS-1:0]            frame_valid_q, frame_paused_q;
  logic [SLOTS-1:0]            once_valid_q, once_paused_q;
  logic [SLOTS-1:0]            rep_valid_q, rep_paused_q;
  // Time left until the next firing; a newly set timer starts at zero.
  logic [TIME_BITS-1:0]        rep_rem_q    [SLOTS];
  logic [TIME_BITS-1:0]        rep_reload_q [SLOTS];
  logic [rtbs_pkg::COUNT_W-1:0] rep_left_q  [SLOTS];

  logic [SLOT_W-1:0]           cmd_idx;
  logic [TIME_BITS-1:0]        cmd_ivl, cmd_dt;
  logic                        last_idx;
  logic                        rep_step, rep_fire, rep_forever;
  logic [rtbs_pkg::COUNT_W-1:0] left_dec;
  logic [rtbs_pkg::TIME_FIELD_W-1:0] passed;

  assign pop_o       = (state_q == ST_IDLE) && !qstat_i.empty;
  assign cmd_idx     = SLOT_W'(cmd_i.slot);
  assign cmd_ivl     = TIME_BITS'(cmd_i.interval);
  assign cmd_dt      = TIME_BITS'(cmd_i.delta_time);
  assign last_idx    = (idx_q == SLOT_W'(SLOTS - 1));
  assign rep_step    = (state_q == ST_REP) && rep_valid_q[idx_q] && !rep_paused_q[idx_q];
  assign rep_fire    = (rep_rem_q[idx_q] <= dt_q);
  assign rep_forever = (rep_left_q[idx_q] == rtbs_pkg::REP_FOREVER);
  assign left_dec    = rep_left_q[idx_q] - rtbs_pkg::COUNT_W'(1);
  assign passed      = rtbs_pkg::TIME_FIELD_W'(dt_q);

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Valid and paused marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q  <= '0;
      frame_paused_q <= '0;
      once_valid_q   <= '0;
      once_paused_q  <= '0;
      rep_valid_q    <= '0;
      rep_paused_q   <= '0;
    end else begin
      if (pop_o) begin
        case (cmd_i.op)
          rtbs_pkg::OP_ONCE_SET: begin
            once_valid_q[cmd_idx]  <= 1'b1;
            once_paused_q[cmd_idx] <= cmd_i.paused;
          end
          rtbs_pkg::OP_REP_SET: begin
            rep_valid_q[cmd_idx]  <= 1'b1;
            rep_paused_q[cmd_idx] <= cmd_i.paused;
          end
          rtbs_pkg::OP_FRAME_SET: begin
            frame_valid_q[cmd_idx]  <= 1'b1;
            frame_paused_q[cmd_idx] <= cmd_i.paused;
          end
          rtbs_pkg::OP_FRAME_CLR: begin
            frame_valid_q[cmd_idx]  <= 1'b0;
            frame_paused_q[cmd_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      // One-shots are spent by any tick, paused or not.
      if (state_q == ST_ONCE) begin
        once_valid_q[idx_q]  <= 1'b0;
        once_paused_q[idx_q] <= 1'b0;
      end
      if (rep_step && rep_fire && !rep_forever && (left_dec == '0)) begin
        rep_valid_q[idx_q]  <= 1'b0;
        rep_paused_q[idx_q] <= 1'b0;
      end
    end
  end

  // Repeating timer payload.
  always_ff @(posedge clk_i) begin
    if (pop_o && (cmd_i.op == rtbs_pkg::OP_REP_SET)) begin
      rep_rem_q[cmd_idx]    <= '0;
      rep_reload_q[cmd_idx] <= cmd_ivl;
      rep_left_q[cmd_idx]   <= cmd_i.repeat_count;
    end
    if (rep_step) begin
      if (rep_fire) begin
        rep_rem_q[idx_q] <= rep_reload_q[idx_q];
        if (!rep_forever) begin
          rep_left_q[idx_q] <= left_dec;
        end
      end else begin
        rep_rem_q[idx_q] <= rep_rem_q[idx_q] - dt_q;
      end
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      dt_q        <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_q.fired_slot  <= rtbs_pkg::SLOT_FIELD_W'(idx_q);
      res_q.passed_time <= passed;
      res_q.last        <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          res_valid_q <= 1'b0;
          idx_q       <= '0;
          if (pop_o && (cmd_i.op == rtbs_pkg::OP_TICK)) begin
            dt_q    <= cmd_dt;
            state_q <= ST_FRAME;
          end
        end
        ST_FRAME: begin
          res_valid_q      <= frame_valid_q[idx_q] && !frame_paused_q[idx_q];
          res_q.fired_kind <= rtbs_pkg::KIND_FRAME;
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= ST_ONCE;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_ONCE: begin
          res_valid_q      <= once_valid_q[idx_q] && !once_paused_q[idx_q];
          res_q.fired_kind <= rtbs_pkg::KIND_ONCE;
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= ST_REP;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_REP: begin
          res_valid_q      <= rep_step && rep_fire;
          res_q.fired_kind <= rtbs_pkg::KIND_REP;
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= ST_END;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_END: begin
          res_valid_q      <= 1'b1;
          res_q.fired_slot <= '0;
          res_q.fired_kind <= rtbs_pkg::KIND_END;
          res_q.last       <= 1'b1;
          state_q          <= ST_IDLE;
        end
        default: begin
          res_valid_q <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/repeating_timer_bank_scheduler.sv =====
// ----------------------------------------------------------------------------
// Repeating timer bank scheduler
// Per-frame, one-shot and repeating timer tables driven by schedule, remove
// and tick items, with one result per fired slot and an end-of-tick marker.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on item_i at a rising edge where start is high and busy
//   is low. Items either schedule a timer, schedule or remove a per-frame
//   slot, or tick the bank by delta_time (unsigned Q12.12 seconds).
//   Schedule and remove items give no result; items naming a slot at or
//   above SLOTS are dropped at the front end.
//   A tick gives one result per fired slot, per-frame slots first, then
//   one-shots, then repeating timers, each in rising slot order, and
//   finally an end-of-tick result with last set.
//   Each result sits on res_o for one cycle with res_strobe_o high; the
//   receiver cannot stall, so results are never held back.
//   Items pass through a QUEUE_DEPTH entry command queue; busy rises only
//   when that queue is full.
//   The back end applies a schedule or remove item as it pops it while idle.
//   A tick walks the three tables at one slot per cycle, then gives the
//   end-of-tick result; no new item is popped until the tick is done, so
//   later items wait in the queue while it runs.
//   Reset clears every valid and paused mark, so all tables start empty.
// ----------------------------------------------------------------------------
`default_nettype none

module repeating_timer_bank_scheduler #(
  parameter int SLOTS       = rtbs_pkg::SLOTS_DEF,
  parameter int TIME_BITS   = rtbs_pkg::TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = rtbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rtbs_pkg::item_t item_i,
  output logic            res_strobe_o,
  output rtbs_pkg::res_t  res_o
);

  // Command path from the front end into the queue.
  logic             push;
  rtbs_pkg::cmd_t   push_cmd;
  // Queue head, seen by the back end, and its status, seen by both ends.
  rtbs_pkg::cmd_t   head_cmd;
  rtbs_pkg::qstat_t qstat;
  logic             pop;

  // The front end classifies each item into a table command and filters
  // out writes to slots that do not exist.
  rtbs_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .start_i (start),
    .item_i  (item_i),
    .qstat_i (qstat),
    .busy_o  (busy),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // The queue lets new items come in while a tick is still being walked.
  rtbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (qstat)
  );

  // The back end owns the tables, so commands take effect strictly in the
  // order the items were accepted.
  rtbs_back #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .res_valid_o (res_strobe_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rtbs_checker.sv =====
// ----------------------------------------------------------------------------
// Timer bank scheduler checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "repeating_timer_bank_scheduler_defines.svh"

module rtbs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           res_strobe_o,
  input rtbs_pkg::res_t res_o
);

  // The last flag marks exactly the end-of-tick result.
  `RTBS_ASSERT_SAME(a_last_is_end, res_strobe_o, (res_o.last == (res_o.fired_kind == rtbs_pkg::KIND_END)), "last flag does not match end-of-tick kind")

  // The end-of-tick result always names slot zero.
  `RTBS_ASSERT_SAME(a_end_slot_zero, res_strobe_o && res_o.last, (res_o.fired_slot == '0), "end-of-tick result names a slot")

  // The back end returns to idle after the end-of-tick result, so the strobe drops before a new tick's first result.
  `RTBS_ASSERT_NEXT(a_gap_after_end, res_strobe_o && res_o.last, !res_strobe_o, "result right after end of tick")

  // Repeating timers come last in a tick, so no earlier table follows them.
  `RTBS_ASSERT_NEXT(a_rep_order, res_strobe_o && (res_o.fired_kind == rtbs_pkg::KIND_REP), !(res_strobe_o && ((res_o.fired_kind == rtbs_pkg::KIND_FRAME) || (res_o.fired_kind == rtbs_pkg::KIND_ONCE))), "table order broken after repeating result")

endmodule

bind repeating_timer_bank_scheduler rtbs_checker u_rtbs_checker (.*);

`default_nettype wire
